// ===== sv/pedestrian_crossing_light_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Pedestrian crossing light controller - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PEDESTRIAN_CROSSING_LIGHT_CONTROLLER_DEFINES_SVH
`define PEDESTRIAN_CROSSING_LIGHT_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
// condition a implies condition b on the same edge
`define PCLC_ASSERT_IMP(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("pclc: implication check failed");
// condition a implies condition b on the next edge
`define PCLC_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("pclc: next-cycle check failed");
`else
`define PCLC_ASSERT_IMP(label, a, b)
`define PCLC_ASSERT_NEXT(label, a, b)
`endif

`endif

// ===== sv/pclc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pedestrian crossing light controller - package
// Phase codes, lamp codes, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package pclc_pkg;

	localparam int TIMER_BITS_DEFAULT = 16;
	localparam int COUNT_BITS_DEFAULT = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 32;
	localparam int TOTAL_W     = 16;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_START_WAIT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GREEN  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_SEC  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_YELLOW_SEC = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_WALK_SEC   = 3'd4;

	// register reset values
	localparam logic [15:0] START_WAIT_RST = 16'd5000;
	localparam logic [15:0] MIN_GREEN_RST  = 16'd1000;
	localparam logic [15:0] TICKS_SEC_RST  = 16'd1000;
	localparam logic [3:0]  YELLOW_SEC_RST = 4'd5;
	localparam logic [3:0]  WALK_SEC_RST   = 4'd10;

	// car lamp codes
	localparam logic [1:0] CAR_OFF    = 2'd0;
	localparam logic [1:0] CAR_GREEN  = 2'd1;
	localparam logic [1:0] CAR_YELLOW = 2'd2;
	localparam logic [1:0] CAR_RED    = 2'd3;

	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_GREEN  = 2'd1,
		PH_YELLOW = 2'd2,
		PH_WALK   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [15:0] start_wait;
		logic [15:0] min_green;
		logic [15:0] ticks_sec;
		logic [3:0]  yellow_sec;
		logic [3:0]  walk_sec;
	} cfg_t;

	// phase and button tracking state
	typedef struct packed {
		phase_t     phase;
		logic [3:0] countdown;
		logic       viol_last;
		logic       viol_armed;
	} ctl_state_t;

	// per-tick lamp and status result, violation total kept apart
	typedef struct packed {
		logic [1:0] car_light;
		logic       ped_green;
		logic       ped_red;
		logic       buzzer_on;
		logic [3:0] seconds_left;
		logic       violation_flash;
	} res_t;

endpackage

// ===== sv/pclc_step.sv =====
// ----------------------------------------------------------------------------
// Pedestrian crossing light controller - tick step
// Next-state and result logic for one tick: phase change, countdown,
// elapsed timer and violation edge counting.
// ----------------------------------------------------------------------------
module pclc_step #(
	parameter int TIMER_BITS = pclc_pkg::TIMER_BITS_DEFAULT,
	parameter int COUNT_BITS = pclc_pkg::COUNT_BITS_DEFAULT
) (
	input  pclc_pkg::cfg_t       cfg,
	input  logic                 walk_button,
	input  logic                 violation_button,
	input  pclc_pkg::ctl_state_t cur,
	input  logic [TIMER_BITS-1:0] elapsed,
	input  logic [COUNT_BITS-1:0] count,
	output pclc_pkg::ctl_state_t nxt,
	output logic [TIMER_BITS-1:0] elapsed_nxt,
	output logic [COUNT_BITS-1:0] count_nxt,
	output pclc_pkg::res_t       res
);
	import pclc_pkg::*;

	localparam int CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

	logic [CMP_W-1:0] elapsed_cmp;
	logic             start_done;
	logic             green_done;
	logic             sec_done;
	logic             stepped;
	logic             changed;
	logic [3:0]       cd_step;
	logic             viol_flash;

	assign elapsed_cmp = CMP_W'(elapsed);
	assign start_done  = elapsed_cmp >= CMP_W'(cfg.start_wait);
	assign green_done  = elapsed_cmp >= CMP_W'(cfg.min_green);
	assign sec_done    = elapsed_cmp >= CMP_W'(cfg.ticks_sec);
	assign stepped     = (cur.countdown != 4'd0) && sec_done;
	assign cd_step     = stepped ? (cur.countdown - 4'd1) : cur.countdown;

	// phase transitions, countdown and violation counting
	always_comb begin
		nxt         = cur;
		changed     = 1'b0;
		elapsed_nxt = elapsed;
		count_nxt   = count;
		viol_flash  = 1'b0;
		case (cur.phase)
			PH_START: begin
				if (start_done) begin
					nxt.phase     = PH_GREEN;
					nxt.countdown = 4'd0;
					changed       = 1'b1;
				end
			end
			PH_GREEN: begin
				if (walk_button && green_done) begin
					nxt.phase     = PH_YELLOW;
					nxt.countdown = cfg.yellow_sec;
					changed       = 1'b1;
				end
			end
			default: begin
				nxt.countdown = cd_step;
				if (cd_step == 4'd0) begin
					changed = 1'b1;
					if (cur.phase == PH_YELLOW) begin
						nxt.phase     = PH_WALK;
						nxt.countdown = cfg.walk_sec;
					end else begin
						nxt.phase     = PH_GREEN;
						nxt.countdown = 4'd0;
					end
				end else if (stepped) begin
					changed = 1'b1;
				end
			end
		endcase

		// restart on change, otherwise count up and hold at full scale
		if (changed) begin
			elapsed_nxt = '0;
		end else if (elapsed != {TIMER_BITS{1'b1}}) begin
			elapsed_nxt = elapsed + TIMER_BITS'(1);
		end

		// violation edge detection, live only in walk
		if (nxt.phase == PH_WALK) begin
			if (violation_button && !cur.viol_last && cur.viol_armed) begin
				if (count != {COUNT_BITS{1'b1}}) begin
					count_nxt = count + COUNT_BITS'(1);
				end
				viol_flash     = 1'b1;
				nxt.viol_armed = 1'b0;
			end
			if (!violation_button) begin
				nxt.viol_armed = 1'b1;
			end
			nxt.viol_last = violation_button;
		end
	end

	// lamp decode from the new phase
	always_comb begin
		res.car_light       = CAR_OFF;
		res.ped_green       = 1'b0;
		res.ped_red         = 1'b0;
		res.buzzer_on       = 1'b0;
		res.seconds_left    = 4'd0;
		res.violation_flash = viol_flash;
		case (nxt.phase)
			PH_GREEN: begin
				res.car_light = CAR_GREEN;
				res.ped_red   = 1'b1;
			end
			PH_YELLOW: begin
				res.car_light    = CAR_YELLOW;
				res.ped_red      = 1'b1;
				res.seconds_left = nxt.countdown;
			end
			PH_WALK: begin
				res.car_light    = CAR_RED;
				res.ped_green    = 1'b1;
				res.buzzer_on    = 1'b1;
				res.seconds_left = nxt.countdown;
			end
			default: begin
				res.car_light = CAR_OFF;
			end
		endcase
	end

endmodule

// ===== sv/pedestrian_crossing_light_controller.sv =====
// ----------------------------------------------------------------------------
// Pedestrian crossing light controller - top level
// Tick-driven car and pedestrian lamp sequencer with violation counting.
// ----------------------------------------------------------------------------
// Each input transfer is one time tick and yields exactly one result transfer
// holding the lamp state after that tick. A tick is worked at its transfer:
// the step logic updates the phase, countdown and counters at the input
// transfer and loads the result register, so one tick per cycle is sustained.
// The input side is ready whenever the result register is empty or is being
// drained in the same cycle; only a stalled result holds off new ticks.
// The user writes registers via the plain write port with no tick in flight
// (not enforced here); they take effect on the next tick that consults them.
`include "pedestrian_crossing_light_controller_defines.svh"

module pedestrian_crossing_light_controller #(
	parameter int TIMER_BITS = pclc_pkg::TIMER_BITS_DEFAULT,
	parameter int COUNT_BITS = pclc_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [pclc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pclc_pkg::CFG_DATA_W-1:0]    cfg_data,
	// tick input
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata fields from bit 0: walk_button, violation_button
	input  logic [pclc_pkg::IN_DATA_W-1:0]     s_tdata,
	// result output
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata fields from bit 0: car_light[1:0], ped_green, ped_red, buzzer_on,
	// seconds_left[3:0], violation_total[15:0], violation_flash
	output logic [pclc_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import pclc_pkg::*;

	localparam int COUNT_EXT_W = COUNT_BITS + TOTAL_W;

	cfg_t                  cfg_q;
	ctl_state_t            ctl_q;
	ctl_state_t            ctl_nxt;
	logic [TIMER_BITS-1:0] elapsed_q;
	logic [TIMER_BITS-1:0] elapsed_nxt;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_nxt;
	res_t                  res_nxt;
	res_t                  res_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [COUNT_EXT_W-1:0] count_ext;
	logic                  out_valid_q;
	logic                  in_xfer;
	logic                  out_xfer;

	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = out_valid_q && m_tready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_wait <= START_WAIT_RST;
			cfg_q.min_green  <= MIN_GREEN_RST;
			cfg_q.ticks_sec  <= TICKS_SEC_RST;
			cfg_q.yellow_sec <= YELLOW_SEC_RST;
			cfg_q.walk_sec   <= WALK_SEC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_WAIT: cfg_q.start_wait <= cfg_data;
				CFG_MIN_GREEN:  cfg_q.min_green  <= cfg_data;
				CFG_TICKS_SEC:  cfg_q.ticks_sec  <= cfg_data;
				CFG_YELLOW_SEC: cfg_q.yellow_sec <= cfg_data[3:0];
				CFG_WALK_SEC:   cfg_q.walk_sec   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	pclc_step #(
		.TIMER_BITS (TIMER_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.cfg              (cfg_q),
		.walk_button      (s_tdata[0]),
		.violation_button (s_tdata[1]),
		.cur              (ctl_q),
		.elapsed          (elapsed_q),
		.count            (count_q),
		.nxt              (ctl_nxt),
		.elapsed_nxt      (elapsed_nxt),
		.count_nxt        (count_nxt),
		.res              (res_nxt)
	);

	assign count_ext = COUNT_EXT_W'(count_nxt);

	// advance state on each tick transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase      <= PH_START;
			ctl_q.countdown  <= 4'd0;
			ctl_q.viol_last  <= 1'b0;
			ctl_q.viol_armed <= 1'b1;
			elapsed_q        <= '0;
			count_q          <= '0;
		end else if (in_xfer) begin
			ctl_q     <= ctl_nxt;
			elapsed_q <= elapsed_nxt;
			count_q   <= count_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded on tick transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q   <= res_nxt;
			total_q <= count_ext[TOTAL_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q.violation_flash, total_q, res_q.seconds_left,
		res_q.buzzer_on, res_q.ped_red, res_q.ped_green, res_q.car_light};

	// checks
	`PCLC_ASSERT_IMP(a_ped_green_car_red, out_valid_q,
		res_q.ped_green == (res_q.car_light == CAR_RED))
	`PCLC_ASSERT_IMP(a_flash_in_walk, out_valid_q && res_q.violation_flash,
		res_q.car_light == CAR_RED)
	`PCLC_ASSERT_IMP(a_secs_only_countdown, out_valid_q && res_q.seconds_left != 4'd0,
		res_q.car_light == CAR_YELLOW || res_q.car_light == CAR_RED)
	`PCLC_ASSERT_NEXT(a_count_no_drop, 1'b1, count_q >= $past(count_q))
	`PCLC_ASSERT_IMP(a_no_overrun, in_xfer, !(out_valid_q && !m_tready))

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedestrian crossing light controller - regression bench
// Streams tick transfers into the controller and checks every lamp result
// against an in-bench phase predictor, under varied timing and register sets.
// ----------------------------------------------------------------------------
module tb_top;
	import pclc_pkg::*;

	// lamp result word, same layout as m_tdata, declared from the top bit down
	typedef struct packed {
		logic [5:0]  pad;
		logic        flash;
		logic [15:0] total;
		logic [3:0]  secs;
		logic        buzzer;
		logic        ped_red;
		logic        ped_green;
		logic [1:0]  car;
	} lamp_word_t;

	// handshake pacing stretches
	typedef enum logic [1:0] {
		PACE_SINK_SLOW,
		PACE_SOURCE_SLOW,
		PACE_FULL
	} pace_t;

	// opening ticks, {violation, walk}: start with buttons held, early and
	// late walk requests, yellow with the violation button, walk with press,
	// hold, release and press again
	localparam logic [1:0] OPENING_TICKS [23] = '{
		2'b11, 2'b11, 2'b10, 2'b01,
		2'b01, 2'b00, 2'b01,
		2'b10, 2'b00, 2'b10, 2'b00,
		2'b10, 2'b10, 2'b00, 2'b10, 2'b11, 2'b00,
		2'b10, 2'b01, 2'b01,
		2'b00, 2'b00, 2'b00
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;

	pace_t      pace = PACE_SINK_SLOW;
	logic [1:0] pending_ticks [$];
	lamp_word_t expected_lamps [$];
	int         mismatches = 0;

	// predictor copy of the registers
	logic [15:0] start_wait = START_WAIT_RST;
	logic [15:0] min_green = MIN_GREEN_RST;
	logic [15:0] tick_period = TICKS_SEC_RST;
	logic [3:0]  yellow_secs = YELLOW_SEC_RST;
	logic [3:0]  walk_secs = WALK_SEC_RST;

	// predictor copy of the controller state
	phase_t      lamp_phase = PH_START;
	logic [15:0] lamp_elapsed = '0;
	logic [3:0]  secs_left = '0;
	logic [15:0] viol_total = '0;
	logic        viol_last = 1'b0;
	logic        viol_armed = 1'b1;

	pedestrian_crossing_light_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void enter_phase(input phase_t next, input logic [3:0] count);
		lamp_phase = next;
		secs_left = count;
		lamp_elapsed = '0;
	endfunction

	// advance the predictor by one tick and build the lamp word it shows
	function automatic lamp_word_t advance_lamps(input logic walk, input logic viol);
		lamp_word_t  word;
		logic [15:0] prior;
		logic        moved;
		logic        stepped;
		logic        flash;
		prior = lamp_elapsed;
		moved = 1'b0;
		stepped = 1'b0;
		flash = 1'b0;
		case (lamp_phase)
			PH_START: begin
				if (prior >= start_wait) begin
					enter_phase(PH_GREEN, 4'd0);
					moved = 1'b1;
				end
			end
			PH_GREEN: begin
				if (walk && prior >= min_green) begin
					enter_phase(PH_YELLOW, yellow_secs);
					moved = 1'b1;
				end
			end
			default: begin
				if (secs_left != 4'd0 && prior >= tick_period) begin
					secs_left = secs_left - 4'd1;
					stepped = 1'b1;
				end
				// countdown at zero ends the phase on this very tick
				if (secs_left == 4'd0) begin
					if (lamp_phase == PH_YELLOW) begin
						enter_phase(PH_WALK, walk_secs);
					end else begin
						enter_phase(PH_GREEN, 4'd0);
					end
					moved = 1'b1;
				end else if (stepped) begin
					lamp_elapsed = '0;
					moved = 1'b1;
				end
			end
		endcase
		if (!moved && lamp_elapsed != 16'hFFFF) begin
			lamp_elapsed = lamp_elapsed + 16'd1;
		end

		// count a violation on a fresh press, only while walking
		if (lamp_phase == PH_WALK) begin
			if (viol && !viol_last && viol_armed) begin
				if (viol_total != 16'hFFFF) begin
					viol_total = viol_total + 16'd1;
				end
				flash = 1'b1;
				viol_armed = 1'b0;
			end
			if (!viol) begin
				viol_armed = 1'b1;
			end
			viol_last = viol;
		end

		word = '0;
		case (lamp_phase)
			PH_GREEN: begin
				word.car = CAR_GREEN;
				word.ped_red = 1'b1;
			end
			PH_YELLOW: begin
				word.car = CAR_YELLOW;
				word.ped_red = 1'b1;
				word.secs = secs_left;
			end
			PH_WALK: begin
				word.car = CAR_RED;
				word.ped_green = 1'b1;
				word.buzzer = 1'b1;
				word.secs = secs_left;
			end
			default: begin
				word.car = CAR_OFF;
			end
		endcase
		word.total = viol_total;
		word.flash = flash;
		return word;
	endfunction

	// write all five registers back to back, then mirror them
	task automatic write_registers(input logic [15:0] wait_ticks, input logic [15:0] green_ticks,
		input logic [15:0] period, input logic [3:0] yellow, input logic [3:0] walk);
		logic [CFG_DATA_W-1:0]  values [5];
		logic [CFG_INDEX_W-1:0] slots [5];
		values = '{wait_ticks, green_ticks, period, 16'(yellow), 16'(walk)};
		slots = '{CFG_START_WAIT, CFG_MIN_GREEN, CFG_TICKS_SEC, CFG_YELLOW_SEC, CFG_WALK_SEC};
		for (int i = 0; i < 5; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= slots[i];
			cfg_data <= values[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		start_wait = wait_ticks;
		min_green = green_ticks;
		tick_period = period;
		yellow_secs = yellow;
		walk_secs = walk;
		@(negedge clk);
	endtask

	// button levels held for random runs, with some scattered noise ticks
	task automatic queue_random_ticks(input int count);
		logic walk;
		logic viol;
		int   walk_run;
		int   viol_run;
		walk = 1'b0;
		viol = 1'b0;
		walk_run = 0;
		viol_run = 0;
		repeat (count) begin
			if (walk_run == 0) begin
				walk = ($urandom_range(0, 9) < 4);
				walk_run = $urandom_range(1, 8);
			end
			if (viol_run == 0) begin
				viol = 1'($urandom_range(0, 1));
				viol_run = $urandom_range(1, 4);
			end
			walk_run--;
			viol_run--;
			if ($urandom_range(0, 9) == 0) begin
				pending_ticks.push_back(2'($urandom));
			end else begin
				pending_ticks.push_back({viol, walk});
			end
		end
	endtask

	// hold until every queued tick went out and every result came back
	task automatic settle();
		while (pending_ticks.size() != 0 || s_tvalid || expected_lamps.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// tick source: predict on each transfer, then offer the next tick
	always @(posedge clk) begin : tick_driver
		logic gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_lamps.push_back(advance_lamps(s_tdata[0], s_tdata[1]));
			end
			case (pace)
				PACE_SINK_SLOW: gap = ($urandom_range(0, 99) < 11);
				PACE_SOURCE_SLOW: gap = ($urandom_range(0, 99) < 50);
				default: gap = 1'b0;
			endcase
			if (!s_tvalid || s_tready) begin
				if (pending_ticks.size() != 0 && !gap) begin
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, pending_ticks.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink: compare each transfer against the oldest prediction
	always @(posedge clk) begin : lamp_monitor
		lamp_word_t seen;
		lamp_word_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata;
				if (expected_lamps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result %h with nothing predicted", m_tdata);
					end
				end else begin
					want = expected_lamps.pop_front();
					if (seen.car !== want.car || seen.ped_green !== want.ped_green ||
						seen.ped_red !== want.ped_red || seen.buzzer !== want.buzzer ||
						seen.secs !== want.secs || seen.total !== want.total ||
						seen.flash !== want.flash) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("lamp mismatch at %0t: car %0d/%0d pg %0b/%0b pr %0b/%0b",
								$realtime, want.car, seen.car, want.ped_green, seen.ped_green,
								want.ped_red, seen.ped_red);
							$display("  buzzer %0b/%0b secs %0d/%0d total %0d/%0d flash %0b/%0b",
								want.buzzer, seen.buzzer, want.secs, seen.secs,
								want.total, seen.total, want.flash, seen.flash);
						end
					end
				end
			end
			case (pace)
				PACE_SINK_SLOW: m_tready <= ($urandom_range(0, 99) >= 50);
				PACE_SOURCE_SLOW: m_tready <= ($urandom_range(0, 99) >= 11);
				default: m_tready <= 1'b1;
			endcase
		end
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening walks through every phase at least once
		pace = PACE_SINK_SLOW;
		write_registers(16'd3, 16'd2, 16'd1, 4'd2, 4'd3);
		foreach (OPENING_TICKS[i]) begin
			pending_ticks.push_back(OPENING_TICKS[i]);
		end
		settle();

		// shortest settings: phases flip almost every tick
		write_registers(16'd1, 16'd0, 16'd1, 4'd1, 4'd1);
		queue_random_ticks(200);
		settle();

		pace = PACE_SOURCE_SLOW;
		write_registers(16'hFFFF, 16'd5, 16'd3, 4'd15, 4'd15);
		queue_random_ticks(200);
		settle();

		pace = PACE_FULL;
		write_registers(START_WAIT_RST, 16'd1, 16'd2, 4'd7, 4'd4);
		queue_random_ticks(280);
		settle();

		// slowest countdown: yellow barely moves
		write_registers(16'hFFFF, 16'd0, 16'hFFFF, 4'd15, 4'd15);
		queue_random_ticks(100);
		settle();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_lamps.size() == 0) begin
			$display("pedestrian_crossing_light_controller regression: pass");
		end else begin
			$display("pedestrian_crossing_light_controller regression: fail");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#20000000;
		$display("pedestrian_crossing_light_controller regression: fail");
		$finish;
	end

endmodule
